/* rtl/core/psaf_pkg.sv */
// ----------------------------------------------------------------------------
// psaf_pkg
// Shared types and constants of the pairing slot address filter.
// ----------------------------------------------------------------------------
package psaf_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_W      = 2;
    localparam int KIND_W      = 3;
    localparam int ADDR_W      = 48;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        KIND_FILTER = 3'd0,
        KIND_ASSIGN = 3'd1,
        KIND_FORGET = 3'd2,
        KIND_WIPE   = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] device_address;
    } t_item;

    typedef struct packed {
        logic              discoverable;
        logic [ADDR_W-1:0] slot_address;
        logic              slot_was_used;
        logic              accepted;
    } t_result;

endpackage

/* rtl/core/psaf_in_stage.sv */
// ----------------------------------------------------------------------------
// psaf_in_stage
// Input register: holds one accepted item until the table takes it.
// ----------------------------------------------------------------------------
module psaf_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psaf_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output psaf_pkg::t_item o_item
);
    import psaf_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // Free when empty, or when the held item leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/psaf_slot_table.sv */
// ----------------------------------------------------------------------------
// psaf_slot_table
// Slot store with parallel address compare, result logic and table update.
// ----------------------------------------------------------------------------
module psaf_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  psaf_pkg::t_item             i_item,
    input  logic [psaf_pkg::SLOT_W-1:0] i_current_slot,
    output psaf_pkg::t_result           o_result
);
    import psaf_pkg::*;

    logic [ADDR_W-1:0] r_addr [NUM_SLOTS];
    logic [ADDR_W-1:0] n_addr [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_used;
    logic [NUM_SLOTS-1:0] n_used;

    t_kind             kind;
    logic [SLOT_W-1:0] target;
    logic              tgt_ok;
    logic              cur_ok;
    logic              tgt_used;
    logic [ADDR_W-1:0] tgt_addr;
    logic [NUM_SLOTS-1:0] match;
    logic              owner_found;
    logic [SLOT_W-1:0] owner_idx;
    logic              accepted;

    assign kind = t_kind'(i_item.kind);

    always_comb begin
        target      = i_item.slot_index;
        tgt_used    = 1'b0;
        tgt_addr    = '0;
        owner_found = 1'b0;
        owner_idx   = '0;
        accepted    = 1'b0;
        n_used      = r_used;
        n_addr      = r_addr;

        if (kind == KIND_FILTER || kind == KIND_ASSIGN) begin
            target = i_current_slot;
        end
        tgt_ok = (int'(target) < NUM_SLOTS);
        cur_ok = (int'(i_current_slot) < NUM_SLOTS);

        // Report the addressed slot as it stands before the operation.
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match[i] = r_used[i] && (r_addr[i] == i_item.device_address);
            if (tgt_ok && target == SLOT_W'(i) && r_used[i]) begin
                tgt_used = 1'b1;
                tgt_addr = r_addr[i];
            end
        end

        // Owner is the lowest used slot holding the address.
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                owner_found = 1'b1;
                owner_idx   = SLOT_W'(i);
            end
        end

        unique case (kind)
            KIND_FILTER: begin
                accepted = !(owner_found && owner_idx != i_current_slot)
                        && !(cur_ok && tgt_used
                             && tgt_addr != i_item.device_address);
            end
            KIND_ASSIGN: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tgt_ok && target == SLOT_W'(i) && !r_used[i]) begin
                        n_used[i] = 1'b1;
                        n_addr[i] = i_item.device_address;
                    end
                end
            end
            KIND_FORGET: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (target == SLOT_W'(i)) begin
                        n_used[i] = 1'b0;
                    end
                end
            end
            KIND_WIPE: begin
                n_used = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_fire) begin
            r_used <= n_used;
        end
    end

    // Address entries only count while the used flag is set.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_addr <= n_addr;
        end
    end

    assign o_result.accepted      = accepted;
    assign o_result.slot_was_used = tgt_used;
    assign o_result.slot_address  = tgt_addr;
    assign o_result.discoverable  = ~&n_used;

endmodule

/* rtl/core/psaf_out_stage.sv */
// ----------------------------------------------------------------------------
// psaf_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module psaf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  psaf_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output psaf_pkg::t_result o_result
);
    import psaf_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/core/pairing_slot_address_filter.sv */
// ----------------------------------------------------------------------------
// pairing_slot_address_filter
// Table of pairing slots with inquiry filter, assign, forget, wipe and read.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the slave stream; tuser carries the operation kind and
//   tdata the slot index and the 48-bit device address. Each item gives
//   exactly one result on the master stream, in order.
//   The configuration channel writes the current slot; write it only while
//   no item is in flight. A value beyond the slot count is dropped.
//   Each item waits in the input register, then the table works in one pass
//   into the result register, which holds the result until it is taken.
//   Throughput: one item per cycle while the receiver takes each result;
//   the single-pass compare of all slots against the address sets that figure.
//   The input register accepts a new item while a finished result waits,
//   so one item is buffered when the receiver stalls; after that tready
//   drops until the result is taken.
//   Reset empties the table, sets the current slot to zero and clears
//   both stages.
// ----------------------------------------------------------------------------
module pairing_slot_address_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [psaf_pkg::SLOT_W-1:0]      i_cfg_data,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] slot_index, [49:2] device_address, [55:50] zero
    input  logic [psaf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] kind
    input  logic [psaf_pkg::KIND_W-1:0]      s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] accepted, [1] slot_was_used, [49:2] slot_address,
    // [50] discoverable, [55:51] zero
    output logic [psaf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import psaf_pkg::*;

    logic [SLOT_W-1:0] r_current_slot;
    t_item             in_item;
    t_item             held_item;
    logic              held_valid;
    logic              out_free;
    logic              take;
    t_result           table_result;
    t_result           out_result;

    // Configuration is always taken; ignore slot numbers beyond the table.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_slot <= '0;
        end else if (i_cfg_valid && int'(i_cfg_data) < NUM_SLOTS) begin
            r_current_slot <= i_cfg_data;
        end
    end

    // Unpack the slave transfer.
    assign in_item.kind           = s_axis_tuser;
    assign in_item.slot_index     = s_axis_tdata[SLOT_W-1:0];
    assign in_item.device_address = s_axis_tdata[SLOT_W +: ADDR_W];

    // Advance the held item whenever the result register has room.
    assign take = held_valid && out_free;

    psaf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    psaf_slot_table u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (take),
        .i_item         (held_item),
        .i_current_slot (r_current_slot),
        .o_result       (table_result)
    );

    psaf_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (table_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    // Pack the result, padding to whole bytes with zeros.
    assign m_axis_tdata = {{(OUT_TDATA_W - ADDR_W - 3){1'b0}},
                           out_result.discoverable,
                           out_result.slot_address,
                           out_result.slot_was_used,
                           out_result.accepted};

endmodule

/* rtl/core/psaf_checker.sv */
// ----------------------------------------------------------------------------
// psaf_checker
// Port-level checks of the pairing slot address filter.
// ----------------------------------------------------------------------------
module psaf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [psaf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import psaf_pkg::*;

    // No result may be pending straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input back-pressure only while a result is blocked downstream.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // An empty slot reports address zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[ADDR_W+1:2] == '0)
        else $error("empty slot reported a non-zero address");

endmodule

bind pairing_slot_address_filter psaf_checker u_psaf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
